FILE: sv/fcwle_pkg.sv
// ----------------------------------------------------------------------------
// fcwle_pkg
// Shared types, byte codes and suffix tables for the front-coded word list
// expander.
// ----------------------------------------------------------------------------
package fcwle_pkg;

  // Control bytes of the compressed stream
  localparam logic [7:0] CH_DOT  = 8'h2E;  // commit pending word
  localparam logic [7:0] CH_POP1 = 8'h2D;  // '-'
  localparam logic [7:0] CH_POP2 = 8'h3D;  // '='
  localparam logic [7:0] CH_POP3 = 8'h5F;  // '_'
  localparam logic [7:0] CH_CR   = 8'h0D;  // emit without suffix
  localparam logic [7:0] SFX_LO  = 8'h01;  // lowest suffix code
  localparam logic [7:0] SFX_HI  = 8'h17;  // highest suffix code
  localparam logic [7:0] CH_LF   = 8'h0A;  // ordinary character inside the range
  localparam logic [6:0] OUT_CR  = 7'h0D;

  typedef enum logic [1:0] {
    CLS_COMMIT,
    CLS_POP,
    CLS_EMIT,
    CLS_APPEND
  } byte_class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_SUFFIX,
    ST_CR
  } fcwle_state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;
    logic do_commit;
    logic do_append;
    logic pop_start;
    logic mv_write;
    logic pop_finish;
    logic emit_start;
    logic load_char;
    logic load_suffix;
    logic load_cr;
    logic finish;
  } fcwle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    byte_class_e cls;
    logic        mv_done;
    logic        at_end;
    logic        sfx_done;
    logic        out_free;
  } fcwle_sts_t;

  // Number of suffix characters for an emit code
  function automatic logic [1:0] sfx_len_f(input logic [4:0] code);
    logic [1:0] len;
    case (code)
      5'd1:                                      len = 2'd3;
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7,
      5'd8, 5'd9, 5'd11, 5'd12:                  len = 2'd2;
      5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd23:                len = 2'd1;
      default:                                   len = 2'd0;
    endcase
    return len;
  endfunction

  // Suffix text, first character in the lowest seven bits
  function automatic logic [20:0] sfx_text_f(input logic [4:0] code);
    logic [20:0] txt;
    case (code)
      5'd1:    txt = {7'h67, 7'h6E, 7'h69};  // ing
      5'd2:    txt = {7'h00, 7'h6C, 7'h61};  // al
      5'd3:    txt = {7'h00, 7'h68, 7'h63};  // ch
      5'd4:    txt = {7'h00, 7'h64, 7'h65};  // ed
      5'd5:    txt = {7'h00, 7'h65, 7'h6C};  // le
      5'd6:    txt = {7'h00, 7'h79, 7'h6C};  // ly
      5'd7:    txt = {7'h00, 7'h73, 7'h75};  // us
      5'd8:    txt = {7'h00, 7'h72, 7'h65};  // er
      5'd9:    txt = {7'h00, 7'h73, 7'h65};  // es
      5'd11:   txt = {7'h00, 7'h65, 7'h69};  // ie
      5'd12:   txt = {7'h00, 7'h67, 7'h6E};  // ng
      5'd14:   txt = {7'h00, 7'h00, 7'h61};  // a
      5'd15:   txt = {7'h00, 7'h00, 7'h64};  // d
      5'd16:   txt = {7'h00, 7'h00, 7'h65};  // e
      5'd17:   txt = {7'h00, 7'h00, 7'h68};  // h
      5'd18:   txt = {7'h00, 7'h00, 7'h6C};  // l
      5'd19:   txt = {7'h00, 7'h00, 7'h6E};  // n
      5'd20:   txt = {7'h00, 7'h00, 7'h72};  // r
      5'd21:   txt = {7'h00, 7'h00, 7'h73};  // s
      5'd22:   txt = {7'h00, 7'h00, 7'h74};  // t
      5'd23:   txt = {7'h00, 7'h00, 7'h79};  // y
      default: txt = '0;
    endcase
    return txt;
  endfunction

endpackage

FILE: sv/fcwle_ctrl.sv
// ----------------------------------------------------------------------------
// fcwle_ctrl
// Sequencer for the expander: decodes each item and steps the datapath
// through prefix moves and word emission.
// ----------------------------------------------------------------------------
module fcwle_ctrl
  import fcwle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  fcwle_sts_t sts_i,
  output fcwle_cmd_t cmd_o
);

  fcwle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts_i.cls)
          CLS_POP:  state_d = ST_MOVE_RD;
          CLS_EMIT: state_d = ST_EMIT_RD;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_MOVE_RD: begin
        state_d = sts_i.mv_done ? ST_IDLE : ST_MOVE_WR;
      end
      ST_MOVE_WR: state_d = ST_MOVE_RD;
      ST_EMIT_RD: begin
        state_d = sts_i.at_end ? ST_SUFFIX : ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts_i.out_free) state_d = ST_EMIT_RD;
      end
      ST_SUFFIX: begin
        if (sts_i.sfx_done) state_d = ST_CR;
      end
      ST_CR: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      ST_DECODE: begin
        case (sts_i.cls)
          CLS_COMMIT: begin
            cmd_o.do_commit = 1'b1;
            cmd_o.finish    = 1'b1;
          end
          CLS_APPEND: begin
            cmd_o.do_append = 1'b1;
            cmd_o.finish    = 1'b1;
          end
          CLS_POP:  cmd_o.pop_start  = 1'b1;
          CLS_EMIT: cmd_o.emit_start = 1'b1;
          default: ;
        endcase
      end
      ST_MOVE_RD: begin
        cmd_o.pop_finish = sts_i.mv_done;
        cmd_o.finish     = sts_i.mv_done;
      end
      ST_MOVE_WR: cmd_o.mv_write = 1'b1;
      ST_EMIT_LD: cmd_o.load_char = sts_i.out_free;
      ST_SUFFIX: begin
        cmd_o.load_suffix = !sts_i.sfx_done && sts_i.out_free;
      end
      ST_CR: begin
        cmd_o.load_cr = sts_i.out_free;
        cmd_o.finish  = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/fcwle_dp.sv
// ----------------------------------------------------------------------------
// fcwle_dp
// Datapath: line store memory, prefix and line lengths, move and emit
// counters, and the output register.
// ----------------------------------------------------------------------------
module fcwle_dp
  import fcwle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fcwle_cmd_t cmd_i,
  output fcwle_sts_t sts_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [6:0] out_char_o,
  output logic       out_last_o,
  output logic       out_ovf_o
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);

  logic [6:0] mem [LINE_DEPTH];

  logic [7:0]    byte_q;
  logic          last_q;
  logic [6:0]    rd_data_q;
  logic [6:0]    out_char_q;
  logic          out_last_q, out_ovf_q;
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] prefix_q, prefix_d, line_q, line_d, idx_q, idx_d;
  logic          dropped_q, dropped_d;
  logic [1:0]    k_q, k_d, spos_q, spos_d;

  byte_class_e   cls;
  logic [1:0]    pop_n, k_calc, sfx_len;
  logic [20:0]   sfx_text;
  logic          has_room;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [6:0]    wr_data;
  logic [CW-1:0] mv_dst;

  // Byte decode
  always_comb begin
    pop_n = 2'd0;
    if (byte_q == CH_DOT) begin
      cls = CLS_COMMIT;
    end else if (byte_q == CH_POP1) begin
      cls = CLS_POP; pop_n = 2'd1;
    end else if (byte_q == CH_POP2) begin
      cls = CLS_POP; pop_n = 2'd2;
    end else if (byte_q == CH_POP3) begin
      cls = CLS_POP; pop_n = 2'd3;
    end else if (byte_q == CH_CR ||
                 (byte_q >= SFX_LO && byte_q <= SFX_HI && byte_q != CH_LF)) begin
      cls = CLS_EMIT;
    end else begin
      cls = CLS_APPEND;
    end
  end

  // Clamp the pop to the prefix
  assign k_calc   = (prefix_q < CW'(pop_n)) ? prefix_q[1:0] : pop_n;
  assign sfx_len  = sfx_len_f(byte_q[4:0]);
  assign sfx_text = sfx_text_f(byte_q[4:0]);
  assign has_room = line_q < DEPTH_C;
  assign mv_dst   = idx_q - CW'(k_q);

  assign sts_o.cls      = cls;
  assign sts_o.mv_done  = (k_q == 2'd0) || (idx_q == line_q);
  assign sts_o.at_end   = idx_q == line_q;
  assign sts_o.sfx_done = spos_q == sfx_len;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = line_q[AW-1:0];
    wr_data = byte_q[6:0];
    if (cmd_i.do_append && has_room) begin
      wr_en = 1'b1;
    end else if (cmd_i.mv_write) begin
      wr_en   = 1'b1;
      wr_addr = mv_dst[AW-1:0];
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (idx_q < DEPTH_C) rd_data_q <= mem[idx_q[AW-1:0]];
  end

  // Lengths and counters
  always_comb begin
    prefix_d    = prefix_q;
    line_d      = line_q;
    dropped_d   = dropped_q;
    idx_d       = idx_q;
    k_d         = k_q;
    spos_d      = spos_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.do_commit) prefix_d = line_q;
    if (cmd_i.do_append) begin
      if (has_room) line_d = line_q + CW'(1);
      else          dropped_d = 1'b1;
      if (byte_q[7]) prefix_d = has_room ? line_q + CW'(1) : line_q;
    end
    if (cmd_i.pop_start) begin
      idx_d = prefix_q;
      k_d   = k_calc;
    end
    if (cmd_i.mv_write) idx_d = idx_q + CW'(1);
    if (cmd_i.pop_finish) begin
      prefix_d = prefix_q - CW'(k_q);
      line_d   = line_q - CW'(k_q);
    end
    if (cmd_i.emit_start) begin
      idx_d  = '0;
      spos_d = 2'd0;
    end
    if (cmd_i.load_char)   idx_d  = idx_q + CW'(1);
    if (cmd_i.load_suffix) spos_d = spos_q + 2'd1;
    if (cmd_i.load_char || cmd_i.load_suffix || cmd_i.load_cr) out_valid_d = 1'b1;
    if (cmd_i.load_cr) begin
      line_d    = prefix_q;
      dropped_d = 1'b0;
    end
    // Drop all line state after the last item of a block
    if (cmd_i.finish && last_q) begin
      prefix_d  = '0;
      line_d    = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= '0;
      line_q      <= '0;
      dropped_q   <= 1'b0;
      idx_q       <= '0;
      k_q         <= 2'd0;
      spos_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      prefix_q    <= prefix_d;
      line_q      <= line_d;
      dropped_q   <= dropped_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      spos_q      <= spos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input capture and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cmd_i.load_char) begin
      out_char_q <= rd_data_q;
      out_last_q <= 1'b0;
      out_ovf_q  <= dropped_q;
    end else if (cmd_i.load_suffix) begin
      out_char_q <= sfx_text[7*spos_q +: 7];
      out_last_q <= 1'b0;
      out_ovf_q  <= dropped_q;
    end else if (cmd_i.load_cr) begin
      out_char_q <= OUT_CR;
      out_last_q <= 1'b1;
      out_ovf_q  <= dropped_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

FILE: sv/front_coded_word_list_expander_top.sv
// ----------------------------------------------------------------------------
// front_coded_word_list_expander_top
// Expands a front-coded word list, one compressed byte per input item, into
// plaintext words closed by a carriage return.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one compressed byte per item in tdata[7:0], tlast
// marks the last byte of a block; all line state is dropped after it.
// Output channel (m_axis): one plaintext character per item in tdata[6:0],
// tlast on the closing carriage return of a word, tuser set on every item of
// a word that lost characters because the line store was full.
// A character, dot or commit byte is finished in the decode state. A pop
// moves each pending character that has to slide down behind the shortened
// prefix with one read and one write on the single line store port pair.
// An emit sends the stored characters, then the suffix characters and the
// closing carriage return; the stored characters are read one at a time
// from the line store, whose read data is registered.
// The output register decouples the sides: the next byte is accepted while
// the closing carriage return still waits. When the receiver stalls, emission
// holds and the item on m_axis stays unchanged.
// Reset clears lengths, the dropped flag and the output valid; the line
// store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module front_coded_word_list_expander_top
  import fcwle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_byte, [7] zero
  output logic       m_axis_tlast,   // last_of_run
  output logic       m_axis_tuser    // [0] overflow
);

  fcwle_cmd_t cmd;
  fcwle_sts_t sts;
  logic [6:0] out_char;

  // Sequencer: accepts an item only when idle, then steps the datapath
  fcwle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line store, lengths and output register
  fcwle_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast),
    .out_ovf_o   (m_axis_tuser)
  );

  // Pad the character to a whole byte
  assign m_axis_tdata = {1'b0, out_char};

endmodule

FILE: sv/fcwle_checker.sv
// ----------------------------------------------------------------------------
// fcwle_checker
// Port-level checks for the expander, bound to the top level.
// ----------------------------------------------------------------------------
module fcwle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("m_axis item changed while stalled");

  // Characters are seven bits wide
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[7])
    else $error("m_axis tdata bit 7 set");

  // A run always closes on a carriage return
  a_out_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h0D)
    else $error("m_axis tlast without carriage return");

  // One item at a time: no acceptance in the cycle after one
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("s_axis ready straight after an accepted item");

endmodule

bind front_coded_word_list_expander_top fcwle_checker u_fcwle_checker (.*);
